FILE: rtl/cpa_pkg.sv
// Shared types, constants and helper functions for the CIGAR pileup accumulator.
// Used by every module in the rtl folder; depends on nothing else.
package cpa_pkg;

	// Default sizing of the pileup store.
	localparam int MAX_REFS_DEF    = 4;
	localparam int MAX_REF_LEN_DEF = 16384;
	localparam int NUM_BASES_DEF   = 4;
	localparam int STORE_DEPTH_DEF = MAX_REFS_DEF * NUM_BASES_DEF * MAX_REF_LEN_DEF;

	// Configuration port.
	localparam int NUM_CFG   = 4;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_W     = 15;
	localparam logic [CFG_W-1:0] REF_LEN_RESET = 15'd16384;

	// Stream widths.
	localparam int IN_DATA_W  = 96;
	localparam int OUT_DATA_W = 112;
	localparam int MODE_W     = 2;
	localparam int STATUS_W   = 2;

	// Item kinds carried in the input tuser.
	typedef enum logic [MODE_W-1:0] {
		MODE_START   = 2'd0,
		MODE_CIGAR   = 2'd1,
		MODE_BASE    = 2'd2,
		MODE_READOUT = 2'd3
	} mode_t;

	// Result status carried in the output tuser.
	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_SKIPPED = 2'd1,
		ST_RANGE   = 2'd2,
		ST_IGNORED = 2'd3
	} status_t;

	// CIGAR operation codes.
	localparam logic [3:0] OP_M  = 4'd0;
	localparam logic [3:0] OP_I  = 4'd1;
	localparam logic [3:0] OP_D  = 4'd2;
	localparam logic [3:0] OP_N  = 4'd3;
	localparam logic [3:0] OP_S  = 4'd4;
	localparam logic [3:0] OP_H  = 4'd5;
	localparam logic [3:0] OP_P  = 4'd6;
	localparam logic [3:0] OP_EQ = 4'd7;
	localparam logic [3:0] OP_X  = 4'd8;

	// Unmapped, secondary and supplementary flag bits.
	localparam logic [11:0] FLAG_FILTER = 12'h904;
	// Phred+33 quality offset.
	localparam logic [6:0] QUAL_OFFSET = 7'd33;

	// Input beat payload, last field in the lowest bits.
	typedef struct packed {
		logic [3:0]  pad;
		logic [1:0]  query_base;
		logic [13:0] query_pos;
		logic [6:0]  qual_char;
		logic [7:0]  base_char;
		logic [19:0] op_length;
		logic [3:0]  cigar_op;
		logic [7:0]  map_quality;
		logic [14:0] start_pos;
		logic [1:0]  ref_index;
		logic [11:0] flag_bits;
	} item_t;

	// One store entry, also the output beat payload.
	typedef struct packed {
		logic [39:0] mapq_sum;
		logic [39:0] quality_sum;
		logic [31:0] base_count;
	} entry_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic capture;
		logic exec;
		logic mem_read;
		logic modify;
		logic load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic need_mem;
	} dp_sts_t;

	typedef struct packed {
		logic       valid;
		logic [1:0] code;
	} base_code_t;

	function automatic logic [31:0] sat_add32(logic [31:0] a, logic [31:0] b);
		logic [32:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[32] ? '1 : s[31:0];
	endfunction

	function automatic logic [39:0] sat_add40(logic [39:0] a, logic [39:0] b);
		logic [40:0] s;
		s = {1'b0, a} + {1'b0, b};
		return s[40] ? '1 : s[39:0];
	endfunction

	// Uppercase A, C, G and T map to codes 0 to 3; anything else is invalid.
	function automatic base_code_t base_lookup(logic [7:0] ch);
		base_code_t r;
		r = '0;
		case (ch)
			8'h41: r = '{valid: 1'b1, code: 2'd0};
			8'h43: r = '{valid: 1'b1, code: 2'd1};
			8'h47: r = '{valid: 1'b1, code: 2'd2};
			8'h54: r = '{valid: 1'b1, code: 2'd3};
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

FILE: rtl/cpa_store.sv
// Single-port-write, single-port-read pileup memory with registered read data.
// Depends on cpa_pkg for the entry type.
module cpa_store #(
	parameter int DEPTH  = cpa_pkg::STORE_DEPTH_DEF,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  cpa_pkg::entry_t   wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output cpa_pkg::entry_t   rdata
);
	import cpa_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rdata_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, data available the cycle after the request.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: rtl/cpa_ctrl.sv
// Sequencing state machine of the pileup accumulator: clearing sweep, item
// execution, store access and result hand-off. Depends on cpa_pkg.
module cpa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  cpa_pkg::dp_sts_t  sts,
	output cpa_pkg::dp_cmd_t  cmd
);
	import cpa_pkg::*;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_EXEC,
		S_READ,
		S_MODIFY,
		S_FINISH
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	// State and output-valid register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					if (sts.clear_last) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= sts.need_mem ? S_READ : S_FINISH;
				end
				S_READ: begin
					state_q <= S_MODIFY;
				end
				S_MODIFY: begin
					state_q <= S_FINISH;
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Command decode.
	always_comb begin
		cmd = '0;
		unique case (state_q)
			S_CLEAR:  cmd.clear_step = 1'b1;
			S_IDLE:   cmd.capture    = in_valid;
			S_EXEC:   cmd.exec       = 1'b1;
			S_READ:   cmd.mem_read   = 1'b1;
			S_MODIFY: cmd.modify     = 1'b1;
			S_FINISH: cmd.load       = out_free;
			default:  cmd = '0;
		endcase
	end

endmodule

FILE: rtl/cpa_datapath.sv
// Datapath of the pileup accumulator: read tracking state, reference lengths,
// store addressing, saturating updates and result registers. Depends on cpa_pkg.
module cpa_datapath #(
	parameter int MAX_REFS    = cpa_pkg::MAX_REFS_DEF,
	parameter int MAX_REF_LEN = cpa_pkg::MAX_REF_LEN_DEF,
	parameter int NUM_BASES   = cpa_pkg::NUM_BASES_DEF,
	parameter int DEPTH       = MAX_REFS * NUM_BASES * MAX_REF_LEN,
	parameter int ADDR_W      = $clog2(DEPTH)
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_write,
	input  logic [cpa_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [cpa_pkg::CFG_W-1:0]     cfg_wdata,
	input  cpa_pkg::item_t                in_item,
	input  cpa_pkg::mode_t                in_mode,
	input  cpa_pkg::dp_cmd_t              cmd,
	output cpa_pkg::dp_sts_t              sts,
	output logic                          st_we,
	output logic [ADDR_W-1:0]             st_waddr,
	output cpa_pkg::entry_t               st_wdata,
	output logic                          st_re,
	output logic [ADDR_W-1:0]             st_raddr,
	input  cpa_pkg::entry_t               st_rdata,
	output cpa_pkg::status_t              out_status,
	output cpa_pkg::entry_t               out_entry
);
	import cpa_pkg::*;

	localparam int ROW_W = $clog2(MAX_REFS * NUM_BASES);
	localparam int POS_W = $clog2(MAX_REF_LEN);
	localparam logic [31:0] MAX_REFS_U  = 32'(MAX_REFS);
	localparam logic [31:0] MAX_LEN_U   = 32'(MAX_REF_LEN);
	localparam logic [31:0] NUM_BASES_U = 32'(NUM_BASES);
	localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);

	// Configuration registers.
	logic [CFG_W-1:0] ref_len_q [NUM_CFG];

	// Captured item.
	item_t item_q;
	mode_t mode_q;

	// Read tracking state.
	logic        active_q;
	logic [1:0]  cur_ref_q;
	logic [7:0]  cur_mapq_q;
	logic [3:0]  pend_op_q;
	logic [19:0] rem_q;
	logic [31:0] target_q;

	// Store access pipeline and clearing sweep.
	logic [ROW_W-1:0]  row_s1;
	logic [POS_W-1:0]  pos_s1;
	logic              is_read_s1;
	logic [ADDR_W-1:0] addr_s2;
	logic [ADDR_W-1:0] clr_addr_q;

	// Result of the item in flight and the output register.
	status_t res_status_q;
	entry_t  res_entry_q;
	status_t out_status_q;
	entry_t  out_entry_q;

	// Next-state values worked out during execution.
	logic        act_d;
	logic [1:0]  ref_d;
	logic [7:0]  mapq_d;
	logic [3:0]  op_d;
	logic [19:0] rem_d;
	logic [31:0] tgt_d;
	status_t     stat_d;
	logic        need_mem;
	logic        is_read_d;
	logic [ROW_W-1:0] row_d;
	logic [POS_W-1:0] pos_d;

	logic [1:0]  sel_ref;
	logic [31:0] len_sel;
	base_code_t  bcode;
	logic [ADDR_W-1:0] addr_w;
	logic [6:0]  qual_val;
	entry_t      upd_entry;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				ref_len_q[i] <= REF_LEN_RESET;
			end
		end else if (cfg_write) begin
			ref_len_q[cfg_index] <= cfg_wdata;
		end
	end

	// Usable length of the reference concerned: the read's own one for a base,
	// the queried one for a readout.
	always_comb begin
		sel_ref = (mode_q == MODE_READOUT) ? item_q.ref_index : cur_ref_q;
		len_sel = 32'(ref_len_q[sel_ref]);
		if (len_sel > MAX_LEN_U) begin
			len_sel = MAX_LEN_U;
		end
		if (32'(sel_ref) >= MAX_REFS_U) begin
			len_sel = '0;
		end
	end

	assign bcode = base_lookup(item_q.base_char);

	// Execution of the captured item against the read tracking state.
	always_comb begin
		act_d     = active_q;
		ref_d     = cur_ref_q;
		mapq_d    = cur_mapq_q;
		op_d      = pend_op_q;
		rem_d     = rem_q;
		tgt_d     = target_q;
		stat_d    = ST_IGNORED;
		need_mem  = 1'b0;
		is_read_d = 1'b0;
		row_d     = '0;
		pos_d     = '0;
		unique case (mode_q)
			MODE_START: begin
				act_d = 1'b0;
				op_d  = OP_M;
				rem_d = '0;
				if ((item_q.flag_bits & FLAG_FILTER) == '0 &&
				    32'(item_q.ref_index) < MAX_REFS_U) begin
					act_d  = 1'b1;
					ref_d  = item_q.ref_index;
					mapq_d = item_q.map_quality;
					tgt_d  = 32'(item_q.start_pos) - 32'd1;
					stat_d = ST_DONE;
				end
			end
			MODE_CIGAR: begin
				if (active_q && item_q.cigar_op <= OP_X) begin
					stat_d = ST_DONE;
					op_d   = item_q.cigar_op;
					rem_d  = '0;
					case (item_q.cigar_op) inside
						OP_M, OP_I, OP_S, OP_EQ, OP_X: rem_d = item_q.op_length;
						OP_D, OP_N: tgt_d = sat_add32(target_q, 32'(item_q.op_length));
						default: ;
					endcase
				end
			end
			MODE_BASE: begin
				if (active_q && rem_q != '0) begin
					rem_d = rem_q - 20'd1;
					if (pend_op_q == OP_I || pend_op_q == OP_S) begin
						// Inserted and soft-clipped bases are consumed only.
						stat_d = ST_DONE;
					end else begin
						tgt_d = sat_add32(target_q, 32'd1);
						if (!bcode.valid) begin
							stat_d = ST_SKIPPED;
						end else if (target_q >= len_sel) begin
							stat_d = ST_RANGE;
						end else begin
							stat_d   = ST_DONE;
							need_mem = 1'b1;
							row_d    = ROW_W'(32'(cur_ref_q) * NUM_BASES_U + 32'(bcode.code));
							pos_d    = POS_W'(target_q);
						end
					end
				end
			end
			MODE_READOUT: begin
				if (32'(item_q.query_pos) < len_sel) begin
					stat_d    = ST_DONE;
					need_mem  = 1'b1;
					is_read_d = 1'b1;
					row_d     = ROW_W'(32'(item_q.ref_index) * NUM_BASES_U +
					                   32'(item_q.query_base));
					pos_d     = POS_W'(32'(item_q.query_pos));
				end else begin
					stat_d = ST_RANGE;
				end
			end
			default: ;
		endcase
	end

	// Captured item payload.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= in_item;
			mode_q <= in_mode;
		end
	end

	// Read tracking state update.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q   <= 1'b0;
			cur_ref_q  <= '0;
			cur_mapq_q <= '0;
			pend_op_q  <= OP_M;
			rem_q      <= '0;
			target_q   <= '0;
		end else if (cmd.exec) begin
			active_q   <= act_d;
			cur_ref_q  <= ref_d;
			cur_mapq_q <= mapq_d;
			pend_op_q  <= op_d;
			rem_q      <= rem_d;
			target_q   <= tgt_d;
		end
	end

	// Store address: row of reference and base, then position within it.
	assign addr_w = ADDR_W'(32'(row_s1) * MAX_LEN_U + 32'(pos_s1));

	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			row_s1     <= row_d;
			pos_s1     <= pos_d;
			is_read_s1 <= is_read_d;
		end
		if (cmd.mem_read) begin
			addr_s2 <= addr_w;
		end
	end

	// Clearing sweep address.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
		end else if (cmd.clear_step) begin
			clr_addr_q <= clr_addr_q + ADDR_W'(1);
		end
	end

	// Saturating update of the entry just read.
	always_comb begin
		qual_val = (item_q.qual_char >= QUAL_OFFSET) ? item_q.qual_char - QUAL_OFFSET : '0;
		upd_entry.base_count  = sat_add32(st_rdata.base_count, 32'd1);
		upd_entry.quality_sum = sat_add40(st_rdata.quality_sum, 40'(qual_val));
		upd_entry.mapq_sum    = sat_add40(st_rdata.mapq_sum, 40'(cur_mapq_q));
	end

	// Store port drive.
	assign st_re    = cmd.mem_read;
	assign st_raddr = addr_w;
	assign st_we    = cmd.clear_step || (cmd.modify && !is_read_s1);
	assign st_waddr = cmd.clear_step ? clr_addr_q : addr_s2;
	assign st_wdata = cmd.clear_step ? '0 : upd_entry;

	// Result of the current item and the output register.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			res_status_q <= stat_d;
			res_entry_q  <= '0;
		end else if (cmd.modify && is_read_s1) begin
			res_entry_q <= st_rdata;
		end
		if (cmd.load) begin
			out_status_q <= res_status_q;
			out_entry_q  <= res_entry_q;
		end
	end

	assign sts.need_mem   = need_mem;
	assign sts.clear_last = (clr_addr_q == LAST_ADDR);
	assign out_status     = out_status_q;
	assign out_entry      = out_entry_q;

endmodule

FILE: rtl/cigar_pileup_accumulator_core.sv
// Top level of the CIGAR pileup accumulator: stream ports, configuration port,
// controller, datapath and pileup store. Depends on cpa_pkg and all rtl modules.
//
// Reads arrive as a start beat, CIGAR element beats and one beat per read base;
// primary reads are piled up per reference, nucleotide and position into a store
// of MAX_REFS * NUM_BASES * MAX_REF_LEN entries, and a readout beat returns one
// entry. Every input beat yields exactly one output beat. After reset the block
// runs a clearing pass that zeroes one store entry a cycle, 262144 entries in the
// default sizing, during which s_axis_tready stays low; configuration writes are
// taken at any time. Items are handled one at a time: start and CIGAR beats,
// uncounted bases and out-of-range readouts pass through execute and finish;
// counted bases and in-range readouts also pass through the store read and
// modify states for the registered read data and write-back to the single store.
// A finished result waits in the output register while the next beat is accepted.
module cigar_pileup_accumulator_core #(
	parameter int MAX_REFS    = cpa_pkg::MAX_REFS_DEF,
	parameter int MAX_REF_LEN = cpa_pkg::MAX_REF_LEN_DEF,
	parameter int NUM_BASES   = cpa_pkg::NUM_BASES_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	// Configuration write port.
	input  logic                           cfg_write,
	input  logic [cpa_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [cpa_pkg::CFG_W-1:0]      cfg_wdata,
	// Input stream.
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// flag_bits, ref_index, start_pos, map_quality, cigar_op, op_length,
	// base_char, qual_char, query_pos, query_base, zero fill
	input  logic [cpa_pkg::IN_DATA_W-1:0]  s_axis_tdata,
	// mode
	input  logic [cpa_pkg::MODE_W-1:0]     s_axis_tuser,
	// Output stream.
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// base_count, quality_sum, mapq_sum
	output logic [cpa_pkg::OUT_DATA_W-1:0] m_axis_tdata,
	// status
	output logic [cpa_pkg::STATUS_W-1:0]   m_axis_tuser
);
	import cpa_pkg::*;

	localparam int DEPTH  = MAX_REFS * NUM_BASES * MAX_REF_LEN;
	localparam int ADDR_W = $clog2(DEPTH);

	dp_cmd_t           dp_cmd;
	dp_sts_t           dp_sts;
	logic              st_we;
	logic [ADDR_W-1:0] st_waddr;
	entry_t            st_wdata;
	logic              st_re;
	logic [ADDR_W-1:0] st_raddr;
	entry_t            st_rdata;
	status_t           out_status;
	entry_t            out_entry;

	// Sequencing.
	cpa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (dp_sts),
		.cmd       (dp_cmd)
	);

	// Read tracking, addressing and arithmetic.
	cpa_datapath #(
		.MAX_REFS    (MAX_REFS),
		.MAX_REF_LEN (MAX_REF_LEN),
		.NUM_BASES   (NUM_BASES),
		.DEPTH       (DEPTH),
		.ADDR_W      (ADDR_W)
	) u_datapath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_write  (cfg_write),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.in_item    (item_t'(s_axis_tdata)),
		.in_mode    (mode_t'(s_axis_tuser)),
		.cmd        (dp_cmd),
		.sts        (dp_sts),
		.st_we      (st_we),
		.st_waddr   (st_waddr),
		.st_wdata   (st_wdata),
		.st_re      (st_re),
		.st_raddr   (st_raddr),
		.st_rdata   (st_rdata),
		.out_status (out_status),
		.out_entry  (out_entry)
	);

	// Pileup store.
	cpa_store #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_store (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	assign m_axis_tdata = OUT_DATA_W'(out_entry);
	assign m_axis_tuser = STATUS_W'(out_status);

	// Only one item is in flight: ready drops straight after an accepted beat.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
		else $error("input accepted while an item is still being worked on");

	// A result is never loaded over one that has not yet been taken.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.load |-> (!m_axis_tvalid || m_axis_tready))
		else $error("result register overwritten before its beat was taken");

	// Store read and write never coincide in the read-modify-write sequence.
	a_store_port: assert property (@(posedge clk) disable iff (!arst_n)
		!(st_we && st_re))
		else $error("store read and write issued in the same cycle");

endmodule

FILE: test/cigar_pileup_accumulator_core_test.sv
// Self-checking testbench for cigar_pileup_accumulator_core: streams reads, CIGAR elements,
// bases and readouts, predicts every result beat from its own pileup model and compares them.
// Depends on cpa_pkg and the core in the rtl folder.
`timescale 1ns / 100ps

module cigar_pileup_accumulator_core_test;
	import cpa_pkg::*;

	localparam int PILEUP_REFS  = MAX_REFS_DEF;
	localparam int PILEUP_LEN   = MAX_REF_LEN_DEF;
	localparam int PILEUP_BASES = NUM_BASES_DEF;

	localparam logic [63:0] U32_CEIL = 64'hFFFF_FFFF;
	localparam logic [63:0] U40_CEIL = 64'hFF_FFFF_FFFF;

	localparam logic [7:0]  CH_A       = "A";
	localparam logic [7:0]  CH_C       = "C";
	localparam logic [7:0]  CH_G       = "G";
	localparam logic [7:0]  CH_T       = "T";
	localparam logic [7:0]  CH_LOWER_A = "a";
	localparam logic [1:0]  NT_A = 2'd0;
	localparam logic [1:0]  NT_C = 2'd1;
	localparam logic [1:0]  NT_G = 2'd2;
	localparam logic [1:0]  NT_T = 2'd3;

	localparam logic [11:0] FLAG_UNMAPPED      = 12'h004;
	localparam logic [11:0] FLAG_SECONDARY     = 12'h100;
	localparam logic [11:0] FLAG_SUPPLEMENTARY = 12'h800;
	localparam logic [3:0]  OP_UNKNOWN         = 4'hF;
	localparam logic [19:0] OP_LEN_MAX         = 20'hF_FFFF;
	localparam logic [13:0] QPOS_MAX           = 14'h3FFF;

	localparam int RANDOM_SCORED_PER_PHASE = 125;
	localparam int SETTLE_CYCLES           = 8;
	localparam int TOUCHED_DEPTH           = 64;
	localparam int RUN_LIMIT_NS            = 15_000_000;

	typedef struct {
		status_t     status;
		logic [31:0] base_count;
		logic [39:0] quality_sum;
		logic [39:0] mapq_sum;
	} pileup_result_t;

	typedef struct packed {
		logic [1:0]  ref_id;
		logic [1:0]  nt;
		logic [13:0] pos;
	} spot_t;

	logic                  clk;
	logic                  arst_n        = 1'b0;
	logic                  cfg_write     = 1'b0;
	logic [CFG_IDX_W-1:0]  cfg_index     = '0;
	logic [CFG_W-1:0]      cfg_wdata     = '0;
	logic                  s_axis_tvalid = 1'b0;
	logic                  s_axis_tready;
	logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
	logic [MODE_W-1:0]     s_axis_tuser  = '0;
	logic                  m_axis_tvalid;
	logic                  m_axis_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_axis_tdata;
	logic [STATUS_W-1:0]   m_axis_tuser;

	// Predicted block state: pileup entries, read walk and reference lengths.
	bit [31:0]        count_tbl [int unsigned];
	bit [39:0]        qual_tbl [int unsigned];
	bit [39:0]        mapq_tbl [int unsigned];
	logic [31:0]      walk_pos    = '0;
	logic             read_open   = 1'b0;
	logic [1:0]       read_ref    = '0;
	logic [7:0]       read_mapq   = '0;
	logic [3:0]       element_op  = OP_M;
	logic [19:0]      bases_left  = '0;
	logic [CFG_W-1:0] ref_len_reg [NUM_CFG];

	pileup_result_t awaited_results[$];
	spot_t          touched_spots[$];

	int src_idle_pct   = 15;
	int sink_idle_pct  = 86;
	int items_sent     = 0;
	int scored_items   = 0;
	int counted_bases  = 0;
	int readout_hits   = 0;
	int results_seen   = 0;
	int mismatch_count = 0;

	cigar_pileup_accumulator_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_write     (cfg_write),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Sums, counts and positions all stop at their ceiling rather than wrapping.
	function automatic logic [63:0] add_clamped(logic [63:0] a, logic [63:0] b,
			logic [63:0] ceiling);
		logic [63:0] s;
		s = a + b;
		return (s > ceiling) ? ceiling : s;
	endfunction

	function automatic bit decode_nucleotide(input logic [7:0] ch, output logic [1:0] nt);
		nt = NT_A;
		case (ch)
			CH_A: nt = NT_A;
			CH_C: nt = NT_C;
			CH_G: nt = NT_G;
			CH_T: nt = NT_T;
			default: return 1'b0;
		endcase
		return 1'b1;
	endfunction

	function automatic logic [31:0] usable_length(logic [1:0] ref_id);
		if (int'(ref_id) >= PILEUP_REFS)
			return '0;
		return (int'(ref_len_reg[ref_id]) > PILEUP_LEN) ? 32'(PILEUP_LEN) :
			32'(ref_len_reg[ref_id]);
	endfunction

	function automatic int unsigned store_key(logic [1:0] ref_id, logic [1:0] nt,
			logic [31:0] pos);
		return (int'(ref_id) * PILEUP_BASES + int'(nt)) * PILEUP_LEN + int'(pos);
	endfunction

	// Works out the result of one accepted beat and advances the predicted state.
	task automatic predict_pileup_result(input mode_t m, input item_t it);
		pileup_result_t r;
		logic [1:0]     nt;
		logic [31:0]    pos;
		logic [6:0]     qv;
		int unsigned    k;
		spot_t          s;
		r = '{status: ST_IGNORED, base_count: '0, quality_sum: '0, mapq_sum: '0};
		case (m)
			MODE_START: begin
				read_open  = 1'b0;
				element_op = OP_M;
				bases_left = '0;
				if ((it.flag_bits & FLAG_FILTER) == '0 && int'(it.ref_index) < PILEUP_REFS) begin
					read_open = 1'b1;
					read_ref  = it.ref_index;
					read_mapq = it.map_quality;
					walk_pos  = {17'd0, it.start_pos} - 32'd1;
					r.status  = ST_DONE;
				end
			end
			MODE_CIGAR: begin
				if (read_open && it.cigar_op <= OP_X) begin
					r.status   = ST_DONE;
					element_op = it.cigar_op;
					bases_left = '0;
					case (it.cigar_op)
						OP_M, OP_I, OP_S, OP_EQ, OP_X: bases_left = it.op_length;
						OP_D, OP_N: walk_pos = 32'(add_clamped(64'(walk_pos),
							64'(it.op_length), U32_CEIL));
						default: ;
					endcase
				end
			end
			MODE_BASE: begin
				if (read_open && bases_left != '0) begin
					bases_left = bases_left - 20'd1;
					if (element_op == OP_I || element_op == OP_S) begin
						r.status = ST_DONE;
					end else begin
						pos      = walk_pos;
						walk_pos = 32'(add_clamped(64'(walk_pos), 64'd1, U32_CEIL));
						if (!decode_nucleotide(it.base_char, nt)) begin
							r.status = ST_SKIPPED;
						end else if (pos >= usable_length(read_ref)) begin
							r.status = ST_RANGE;
						end else begin
							k  = store_key(read_ref, nt, pos);
							qv = (it.qual_char >= QUAL_OFFSET) ? it.qual_char - QUAL_OFFSET : '0;
							if (!count_tbl.exists(k)) begin
								count_tbl[k] = '0;
								qual_tbl[k]  = '0;
								mapq_tbl[k]  = '0;
							end
							count_tbl[k] = 32'(add_clamped(64'(count_tbl[k]), 64'd1, U32_CEIL));
							qual_tbl[k]  = 40'(add_clamped(64'(qual_tbl[k]), 64'(qv), U40_CEIL));
							mapq_tbl[k]  = 40'(add_clamped(64'(mapq_tbl[k]), 64'(read_mapq),
								U40_CEIL));
							r.status = ST_DONE;
							counted_bases++;
							s.ref_id = read_ref;
							s.nt     = nt;
							s.pos    = pos[13:0];
							touched_spots = {touched_spots, s};
							if (touched_spots.size() > TOUCHED_DEPTH)
								void'(touched_spots.pop_front());
						end
					end
				end
			end
			default: begin
				if (32'(it.query_pos) < usable_length(it.ref_index)) begin
					k = store_key(it.ref_index, it.query_base, 32'(it.query_pos));
					r.status = ST_DONE;
					if (count_tbl.exists(k)) begin
						r.base_count  = count_tbl[k];
						r.quality_sum = qual_tbl[k];
						r.mapq_sum    = mapq_tbl[k];
					end
					readout_hits++;
				end else begin
					r.status = ST_RANGE;
				end
			end
		endcase
		if (r.status != ST_IGNORED)
			scored_items++;
		awaited_results = {awaited_results, r};
	endtask

	// Presents one beat after a random idle gap and waits for the block to take it.
	task automatic send_item(input mode_t m, input item_t it);
		while ($urandom_range(99) < src_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser  <= m;
		s_axis_tdata  <= it;
		do @(posedge clk); while (!s_axis_tready);
		items_sent++;
		predict_pileup_result(m, it);
	endtask

	// Fields that a mode does not use carry random bits, so every bit but the zero fill toggles.
	function automatic item_t random_fields();
		item_t it;
		it = {$urandom, $urandom, $urandom};
		it.pad = '0;
		return it;
	endfunction

	task automatic send_start(input logic [11:0] flag, input logic [1:0] ref_id,
			input logic [14:0] spos, input logic [7:0] mapq);
		item_t it;
		it = random_fields();
		it.flag_bits   = flag;
		it.ref_index   = ref_id;
		it.start_pos   = spos;
		it.map_quality = mapq;
		send_item(MODE_START, it);
	endtask

	task automatic send_cigar(input logic [3:0] op, input logic [19:0] len);
		item_t it;
		it = random_fields();
		it.cigar_op  = op;
		it.op_length = len;
		send_item(MODE_CIGAR, it);
	endtask

	task automatic send_base(input logic [7:0] ch, input logic [6:0] qual);
		item_t it;
		it = random_fields();
		it.base_char = ch;
		it.qual_char = qual;
		send_item(MODE_BASE, it);
	endtask

	task automatic send_readout(input logic [1:0] ref_id, input logic [13:0] pos,
			input logic [1:0] nt);
		item_t it;
		it = random_fields();
		it.ref_index  = ref_id;
		it.query_pos  = pos;
		it.query_base = nt;
		send_item(MODE_READOUT, it);
	endtask

	// Lets every awaited result arrive and the store write-back settle.
	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (awaited_results.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes all four reference lengths, one register per cycle.
	task automatic write_ref_lengths(input logic [CFG_W-1:0] len0, len1, len2, len3);
		logic [CFG_W-1:0] lens [NUM_CFG];
		lens[0] = len0;
		lens[1] = len1;
		lens[2] = len2;
		lens[3] = len3;
		for (int i = 0; i < NUM_CFG; i++) begin
			cfg_write      <= 1'b1;
			cfg_index      <= CFG_IDX_W'(i);
			cfg_wdata      <= lens[i];
			ref_len_reg[i]  = lens[i];
			@(posedge clk);
		end
		cfg_write <= 1'b0;
	endtask

	function automatic logic [3:0] pick_cigar_op();
		case ($urandom_range(13))
			0: return OP_I;
			1: return OP_D;
			2: return OP_N;
			3: return OP_S;
			4: return OP_H;
			5: return OP_P;
			6: return OP_EQ;
			7: return OP_X;
			8: return 4'($urandom_range(15, int'(OP_X) + 1));
			default: return OP_M;
		endcase
	endfunction

	function automatic logic [7:0] random_base_char();
		case ($urandom_range(9))
			0: return 8'($urandom);
			1, 2: return CH_A;
			3, 4: return CH_C;
			5, 6: return CH_G;
			default: return CH_T;
		endcase
	endfunction

	function automatic logic [6:0] random_qual();
		if ($urandom_range(19) == 0)
			return 7'($urandom_range(127));
		return 7'($urandom_range(126, 33));
	endfunction

	// Mostly revisits entries that hold counts, otherwise any position.
	task automatic random_readout();
		spot_t s;
		if (touched_spots.size() != 0 && $urandom_range(2) != 0) begin
			s = touched_spots[$urandom_range(touched_spots.size() - 1)];
			send_readout(s.ref_id, s.pos, s.nt);
		end else begin
			send_readout(2'($urandom), 14'($urandom), 2'($urandom));
		end
	endtask

	// One read: a start beat, a few CIGAR elements, and their bases, sometimes cut
	// short or followed by a stray base.
	task automatic random_read();
		logic [1:0]  ref_id;
		logic [14:0] spos;
		logic [11:0] flag;
		logic [3:0]  op;
		logic [19:0] len;
		int          n_bases;
		ref_id = 2'($urandom);
		case ($urandom_range(19))
			0: spos = '0;
			1: spos = 15'($urandom_range(32767, 1));
			default: spos = 15'($urandom_range(usable_length(ref_id), 1));
		endcase
		flag = 12'($urandom);
		if ($urandom_range(9) != 0)
			flag = flag & ~FLAG_FILTER;
		send_start(flag, ref_id, spos, 8'($urandom));
		repeat ($urandom_range(4, 1)) begin
			op  = pick_cigar_op();
			len = ($urandom_range(9) == 0) ? 20'($urandom) : 20'($urandom_range(6));
			send_cigar(op, len);
			if (op == OP_M || op == OP_I || op == OP_S || op == OP_EQ || op == OP_X) begin
				n_bases = (len > 20'd8) ? int'($urandom_range(3)) : int'(len);
				if ($urandom_range(9) == 0)
					n_bases++;
				repeat (n_bases) send_base(random_base_char(), random_qual());
			end
		end
		if ($urandom_range(1) != 0)
			random_readout();
	endtask

	// Flag filtering: unmapped, secondary and supplementary reads are dropped, and
	// elements or bases with no open read are ignored.
	task automatic test_flag_filter();
		send_start(FLAG_UNMAPPED, 2'd0, 15'd1, 8'd60);
		send_cigar(OP_M, 20'd2);
		send_start(FLAG_SECONDARY, 2'd1, 15'd1, 8'd60);
		send_base(CH_A, 7'd70);
		send_start(FLAG_SUPPLEMENTARY, 2'd3, 15'd16384, 8'd60);
	endtask

	// Walks one read through every CIGAR operation, an unknown code, a base with
	// nothing pending, an element replaced early, a lowercase base, a quality below
	// the offset and a skip past the end of the reference.
	task automatic test_cigar_walk();
		send_start(~FLAG_FILTER, 2'd0, 15'd1, 8'd255);
		send_cigar(OP_UNKNOWN, 20'd3);
		send_base(CH_A, 7'd60);
		send_cigar(OP_S, 20'd1);
		send_base(CH_C, 7'd60);
		send_cigar(OP_H, 20'd7);
		send_cigar(OP_P, 20'd7);
		send_cigar(OP_M, 20'd2);
		send_base(CH_A, 7'd126);
		send_cigar(OP_EQ, 20'd1);
		send_base(CH_LOWER_A, 7'd50);
		send_cigar(OP_D, 20'd2);
		send_cigar(OP_X, 20'd1);
		send_base(CH_T, 7'd20);
		send_cigar(OP_I, 20'd1);
		send_base(CH_G, 7'd40);
		send_cigar(OP_N, OP_LEN_MAX);
		send_cigar(OP_M, 20'd1);
		send_base(CH_A, 7'd33);
	endtask

	// Start position zero puts the walk at the top of the range, where it sticks.
	task automatic test_position_saturation();
		send_start('0, 2'd1, 15'd0, 8'd0);
		send_cigar(OP_D, OP_LEN_MAX);
		send_cigar(OP_M, 20'd1);
		send_base(CH_G, 7'd33);
	endtask

	// Reads back the entries written above, one beyond a length of one, and the last
	// position of a full-length reference.
	task automatic test_readout();
		send_readout(2'd0, 14'd0, NT_A);
		send_readout(2'd0, 14'd4, NT_T);
		send_readout(2'd1, 14'd1, NT_C);
		send_readout(2'd0, QPOS_MAX, NT_G);
	endtask

	// Random reads with readouts and stray beats mixed in, under one idling pattern.
	task automatic test_random_reads(input int src_pct, input int sink_pct);
		int target;
		int pick;
		src_idle_pct  = src_pct;
		sink_idle_pct = sink_pct;
		target        = scored_items + RANDOM_SCORED_PER_PHASE;
		while (scored_items < target) begin
			pick = $urandom_range(9);
			if (pick == 0) begin
				random_readout();
			end else if (pick == 1) begin
				if ($urandom_range(1) != 0)
					send_base(random_base_char(), random_qual());
				else
					send_cigar(pick_cigar_op(), 20'($urandom_range(4)));
			end else begin
				random_read();
			end
		end
		drain_results();
	endtask

	// Result side: random back-pressure, and each accepted beat against the oldest
	// prediction.
	initial begin : result_checker
		entry_t         got;
		pileup_result_t want;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				got = m_axis_tdata;
				results_seen++;
				if (awaited_results.size() == 0) begin
					$error("result beat with nothing awaited: status %0d", m_axis_tuser);
					mismatch_count++;
				end else begin
					want = awaited_results.pop_front();
					if (m_axis_tuser !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, m_axis_tuser);
						mismatch_count++;
					end
					if (got.base_count !== want.base_count) begin
						$error("base_count: expected %0d, got %0d", want.base_count,
							got.base_count);
						mismatch_count++;
					end
					if (got.quality_sum !== want.quality_sum) begin
						$error("quality_sum: expected %0d, got %0d", want.quality_sum,
							got.quality_sum);
						mismatch_count++;
					end
					if (got.mapq_sum !== want.mapq_sum) begin
						$error("mapq_sum: expected %0d, got %0d", want.mapq_sum, got.mapq_sum);
						mismatch_count++;
					end
				end
			end
			m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
		end
	end

	// Sequence of tests; the store clearing pass after reset holds off the first beat.
	initial begin
		foreach (ref_len_reg[i])
			ref_len_reg[i] = REF_LEN_RESET;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		write_ref_lengths(15'd16384, 15'd1, 15'd16383, 15'd9);
		test_flag_filter();
		test_cigar_walk();
		test_position_saturation();
		test_readout();
		drain_results();
		test_random_reads(15, 86);

		write_ref_lengths(15'd1, 15'd16384, CFG_W'($urandom_range(16384, 1)),
			CFG_W'($urandom_range(64, 1)));
		test_random_reads(86, 15);

		write_ref_lengths(CFG_W'($urandom_range(16384, 1)), CFG_W'($urandom_range(16384, 1)),
			CFG_W'($urandom_range(200, 1)), CFG_W'($urandom_range(16384, 1)));
		test_random_reads(0, 0);

		$display("Sent %0d beats and checked %0d results over three idling phases and",
			items_sent, results_seen);
		$display("three length settings: %0d bases piled up, %0d readouts within range.",
			counted_bases, readout_hits);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// Watchdog for a hung handshake.
	initial begin
		#(RUN_LIMIT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

FILE: cigar_pileup_accumulator_core.f
rtl/cpa_pkg.sv
rtl/cpa_store.sv
rtl/cpa_ctrl.sv
rtl/cpa_datapath.sv
rtl/cigar_pileup_accumulator_core.sv
test/cigar_pileup_accumulator_core_test.sv
